// File: sv/nfp_pkg.sv
// nfp_pkg: fixed-point types, constants and unit-root tables for newton_fractal_pixel
// no dependencies; used by sv/newton_fractal_pixel.sv and sim/testbench.sv
package nfp_pkg;

  localparam int FRAC           = 28;
  localparam int DEF_MAX_SIDE   = 4096;
  localparam int DEF_MAX_DEGREE = 9;
  localparam int ROM_SIZE       = 9;
  localparam int AW             = 4;

  typedef logic signed [63:0] fx_t;

  localparam fx_t LIMIT     = 64'sh3FFF_FFFF_FFFF_FFFF;
  localparam fx_t ONE       = fx_t'(64'd1 << FRAC);
  localparam fx_t START_OFS = fx_t'(64'd2 << FRAC);
  localparam fx_t THRESH    = 64'sd268435;
  localparam fx_t DIVERGE   = fx_t'(64'd100000 << FRAC);
  localparam logic [63:0] RECIP_NUM = 64'd1 << 56;

  localparam logic [1:0] REG_EXPONENT = 2'd0;
  localparam logic [1:0] REG_SIDE     = 2'd1;
  localparam logic [1:0] REG_CAP      = 2'd2;

  function automatic fx_t from_dec(input longint v);
    longint unsigned m;
    longint unsigned r;
    m = (v < 0) ? longint'(-v) : longint'(v);
    r = ((m << FRAC) + 64'd500000000) / 64'd1000000000;
    return (v < 0) ? fx_t'(-longint'(r)) : fx_t'(longint'(r));
  endfunction

  localparam fx_t W1_RE [ROM_SIZE] = '{
    from_dec(1000000000), from_dec(-1000000000), from_dec(-500000000),
    from_dec(0), from_dec(309016994), from_dec(500000000),
    from_dec(623489802), from_dec(707106781), from_dec(766044443)};

  localparam fx_t W1_IM [ROM_SIZE] = '{
    from_dec(0), from_dec(0), from_dec(866025404),
    from_dec(1000000000), from_dec(951056516), from_dec(866025404),
    from_dec(781831482), from_dec(707106781), from_dec(642787610)};

  // c1 = round-ish (d-1)/d
  localparam fx_t C1 [ROM_SIZE] = '{
    fx_t'((64'd0 + 64'd0) / 64'd1),
    fx_t'(((64'd1 << FRAC) + 64'd1) / 64'd2),
    fx_t'(((64'd2 << FRAC) + 64'd1) / 64'd3),
    fx_t'(((64'd3 << FRAC) + 64'd2) / 64'd4),
    fx_t'(((64'd4 << FRAC) + 64'd2) / 64'd5),
    fx_t'(((64'd5 << FRAC) + 64'd3) / 64'd6),
    fx_t'(((64'd6 << FRAC) + 64'd3) / 64'd7),
    fx_t'(((64'd7 << FRAC) + 64'd4) / 64'd8),
    fx_t'(((64'd8 << FRAC) + 64'd4) / 64'd9)};

  localparam fx_t LIMDIV [ROM_SIZE] = '{
    fx_t'(LIMIT / 64'sd1), fx_t'(LIMIT / 64'sd2), fx_t'(LIMIT / 64'sd3),
    fx_t'(LIMIT / 64'sd4), fx_t'(LIMIT / 64'sd5), fx_t'(LIMIT / 64'sd6),
    fx_t'(LIMIT / 64'sd7), fx_t'(LIMIT / 64'sd8), fx_t'(LIMIT / 64'sd9)};

  typedef struct packed {
    fx_t  a0;
    fx_t  b0;
    fx_t  a1;
    fx_t  b1;
    logic neg;
  } pair_ops_t;

endpackage

// File: sv/newton_fractal_pixel.sv
// newton_fractal_pixel: per-pixel newton iteration for z^d - 1, one shared multiplier
// depends on nfp_pkg; newton steps run on the shared 32x32 multiplier and the
// one-bit-per-cycle 64-step divider; one item at a time, busy meanwhile
// result strobe done_o lasts one cycle; the receiver cannot stall
// reset: idle, exponent 3, image_side 1024, iteration_cap 255
module newton_fractal_pixel
  import nfp_pkg::*;
#(
  parameter int MAX_SIDE   = DEF_MAX_SIDE,
  parameter int MAX_DEGREE = DEF_MAX_DEGREE
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [AW-1:0] paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready,
  input  logic          start,
  output logic          busy,
  input  logic [11:0]   column_index_i,
  input  logic [11:0]   row_index_i,
  output logic          done_o,
  output logic [3:0]    root_code_o,
  output logic [7:0]    iteration_count_o
);

  localparam int IW = $clog2(MAX_DEGREE + 1);
  localparam int KW = $clog2(MAX_DEGREE + 2);

  typedef enum logic [18:0] {
    S_IDLE    = 19'd1,
    S_MUL     = 19'd2,
    S_FIN     = 19'd4,
    S_DIV     = 19'd8,
    S_SRE     = 19'd16,
    S_SIM     = 19'd32,
    S_ROOT    = 19'd64,
    S_ROOT_IM = 19'd128,
    S_ROOT_WR = 19'd256,
    S_ITER    = 19'd512,
    S_POW     = 19'd1024,
    S_POW_IM  = 19'd2048,
    S_POW_WR  = 19'd4096,
    S_TDIV    = 19'd8192,
    S_UPD_RE  = 19'd16384,
    S_UPD_IM  = 19'd32768,
    S_UPD_WR  = 19'd65536,
    S_DIST    = 19'd131072,
    S_DCHK    = 19'd262144
  } state_e;

  function automatic fx_t csum(input fx_t a, input fx_t b);
    logic signed [64:0] s;
    logic signed [64:0] lim;
    lim = {1'b0, LIMIT};
    s = $signed({a[63], a}) + $signed({b[63], b});
    if (s > lim) return LIMIT;
    if (s < -lim) return -LIMIT;
    return s[63:0];
  endfunction

  function automatic logic [63:0] mag(input fx_t a);
    return a[63] ? 64'(-a) : 64'(a);
  endfunction

  state_e state_q, state_d, ret_q, ret_d;
  logic [3:0]  exponent_q;
  logic [12:0] image_side_q;
  logic [7:0]  iteration_cap_q;
  logic [3:0]  d_q, d_d;
  logic [7:0]  cap_q, cap_d, step_q, step_d;
  logic [11:0] row_q, row_d;
  logic [KW-1:0] k_q, k_d;
  fx_t zr_q, zr_d, zi_q, zi_d, pr_q, pr_d, pi_q, pi_d, tmp_q, tmp_d;
  fx_t f0_q, f0_d, res_q, res_d;
  pair_ops_t ops_q, ops_d;
  logic half_q, half_d;
  logic [1:0] pp_q, pp_d;
  logic [127:0] acc_q, acc_d;
  logic [63:0] rem_q, rem_d, quo_q, quo_d, dvs_q, dvs_d;
  logic [5:0] dcnt_q, dcnt_d;
  logic [3:0] code_q, code_d;
  logic [7:0] count_q, count_d;
  logic done_q, done_d;
  fx_t root_re_q [MAX_DEGREE + 1];
  fx_t root_im_q [MAX_DEGREE + 1];
  logic root_we;
  logic [IW-1:0] root_wa, root_ra;
  fx_t root_wre, root_wim, wr, wi;
  logic cfg_we;

  assign pready = 1'b1;
  assign busy = (state_q != S_IDLE);
  assign done_o = done_q;
  assign root_code_o = code_q;
  assign iteration_count_o = count_q;
  assign cfg_we = psel & penable & pwrite;

  always_comb begin
    prdata = 32'd0;
    case (paddr[3:2])
      REG_EXPONENT: prdata = 32'(exponent_q);
      REG_SIDE:     prdata = 32'(image_side_q);
      REG_CAP:      prdata = 32'(iteration_cap_q);
      default:      prdata = 32'd0;
    endcase
  end

  always_comb begin
    logic [KW-1:0] km1;
    km1 = k_q - KW'(1);
    root_ra = (state_q == S_DIST) ? k_q[IW-1:0] : km1[IW-1:0];
    wr = (k_q == '0) ? fx_t'(0) : root_re_q[root_ra];
    wi = (k_q == '0) ? fx_t'(0) : root_im_q[root_ra];
  end

  always_comb begin
    logic [63:0] xm, ym, pprod;
    logic [31:0] xs, ys;
    logic [1:0] sh;
    logic [63:0] mm;
    logic sgn;
    fx_t f, dr, di, t;
    logic [66:0] tprod;
    logic [64:0] trial;
    logic [3:0] de;
    logic [12:0] se;
    logic start_pair, start_div;
    pair_ops_t nops;
    logic [63:0] dvd;

    state_d = state_q; ret_d = ret_q; d_d = d_q; cap_d = cap_q; step_d = step_q;
    row_d = row_q; k_d = k_q; zr_d = zr_q; zi_d = zi_q; pr_d = pr_q; pi_d = pi_q;
    tmp_d = tmp_q; f0_d = f0_q; res_d = res_q; ops_d = ops_q; half_d = half_q;
    pp_d = pp_q; acc_d = acc_q; rem_d = rem_q; quo_d = quo_q; dvs_d = dvs_q;
    dcnt_d = dcnt_q; code_d = code_q; count_d = count_q; done_d = 1'b0;
    root_we = 1'b0; root_wa = k_q[IW-1:0]; root_wre = tmp_q; root_wim = res_q;
    start_pair = 1'b0; start_div = 1'b0; nops = ops_q; dvd = 64'd0;

    xm = half_q ? mag(ops_q.a1) : mag(ops_q.a0);
    ym = half_q ? mag(ops_q.b1) : mag(ops_q.b0);
    xs = pp_q[1] ? xm[63:32] : xm[31:0];
    ys = pp_q[0] ? ym[63:32] : ym[31:0];
    pprod = xs * ys;
    sh = {1'b0, pp_q[1]} + {1'b0, pp_q[0]};
    sgn = half_q ? (ops_q.a1[63] ^ ops_q.b1[63]) : (ops_q.a0[63] ^ ops_q.b0[63]);
    mm = acc_q[91:28];
    if ((|acc_q[127:92]) || (mm > 64'(LIMIT))) mm = 64'(LIMIT);
    f = sgn ? -fx_t'(mm) : fx_t'(mm);
    dr = csum(zr_q, -wr);
    di = csum(zi_q, -wi);
    tprod = 67'(res_q) * 67'(d_q);
    t = (res_q > LIMDIV[4'(d_q - 4'd1)]) ? LIMIT : fx_t'(tprod[63:0]);
    trial = {rem_q, quo_q[63]};
    de = exponent_q;
    if (de == 4'd0) de = 4'd1;
    if (de > 4'(MAX_DEGREE)) de = 4'(MAX_DEGREE);
    se = image_side_q;
    if (se == 13'd0) se = 13'd1;
    if (17'(se) > 17'(MAX_SIDE)) se = 13'(MAX_SIDE);

    case (state_q)
      S_IDLE: begin
        if (start) begin
          d_d = de;
          cap_d = (iteration_cap_q == 8'd0) ? 8'd1 : iteration_cap_q;
          row_d = row_index_i;
          dvs_d = 64'(se);
          dvd = 64'(column_index_i) << 30;
          start_div = 1'b1;
          ret_d = S_SRE;
        end
      end
      S_MUL: begin
        acc_d = acc_q + ({64'd0, pprod} << {sh, 5'd0});
        pp_d = pp_q + 2'd1;
        if (pp_q == 2'd3) state_d = S_FIN;
      end
      S_FIN: begin
        if (!half_q) begin
          f0_d = f;
          half_d = 1'b1;
          acc_d = '0;
          pp_d = 2'd0;
          state_d = S_MUL;
        end else begin
          res_d = csum(f0_q, ops_q.neg ? -f : f);
          state_d = ret_q;
        end
      end
      S_DIV: begin
        if (trial >= {1'b0, dvs_q}) begin
          rem_d = 64'(trial - {1'b0, dvs_q});
          quo_d = {quo_q[62:0], 1'b1};
        end else begin
          rem_d = trial[63:0];
          quo_d = {quo_q[62:0], 1'b0};
        end
        dcnt_d = dcnt_q + 6'd1;
        if (dcnt_q == 6'd63) state_d = ret_q;
      end
      S_SRE: begin
        zr_d = fx_t'(quo_q) - START_OFS;
        dvd = 64'(row_q) << 30;
        start_div = 1'b1;
        ret_d = S_SIM;
      end
      S_SIM: begin
        zi_d = fx_t'(quo_q) - START_OFS;
        root_we = 1'b1;
        root_wa = IW'(1);
        root_wre = W1_RE[4'(d_q - 4'd1)];
        root_wim = W1_IM[4'(d_q - 4'd1)];
        k_d = KW'(2);
        state_d = S_ROOT;
      end
      S_ROOT: begin
        if (4'(k_q) > d_q) begin
          state_d = S_ITER;
        end else begin
          nops = '{wr, root_re_q[1], wi, root_im_q[1], 1'b1};
          start_pair = 1'b1;
          ret_d = S_ROOT_IM;
        end
      end
      S_ROOT_IM: begin
        tmp_d = res_q;
        nops = '{wr, root_im_q[1], wi, root_re_q[1], 1'b0};
        start_pair = 1'b1;
        ret_d = S_ROOT_WR;
      end
      S_ROOT_WR: begin
        root_we = 1'b1;
        k_d = k_q + KW'(1);
        state_d = S_ROOT;
      end
      S_ITER: begin
        pr_d = ONE;
        pi_d = '0;
        k_d = KW'(1);
        state_d = S_POW;
      end
      S_POW: begin
        if (4'(k_q) >= d_q) begin
          nops = '{pr_q, pr_q, pi_q, pi_q, 1'b0};
          ret_d = S_TDIV;
        end else begin
          nops = '{pr_q, zr_q, pi_q, zi_q, 1'b1};
          ret_d = S_POW_IM;
        end
        start_pair = 1'b1;
      end
      S_POW_IM: begin
        tmp_d = res_q;
        nops = '{pr_q, zi_q, pi_q, zr_q, 1'b0};
        start_pair = 1'b1;
        ret_d = S_POW_WR;
      end
      S_POW_WR: begin
        pr_d = tmp_q;
        pi_d = res_q;
        k_d = k_q + KW'(1);
        state_d = S_POW;
      end
      S_TDIV: begin
        if (t == '0) begin
          code_d = 4'd0;
          count_d = step_q;
          done_d = 1'b1;
          state_d = S_IDLE;
        end else begin
          dvs_d = 64'(t);
          dvd = RECIP_NUM;
          start_div = 1'b1;
          ret_d = S_UPD_RE;
        end
      end
      S_UPD_RE: begin
        nops = '{C1[4'(d_q - 4'd1)], zr_q, pr_q, fx_t'(quo_q), 1'b0};
        start_pair = 1'b1;
        ret_d = S_UPD_IM;
      end
      S_UPD_IM: begin
        tmp_d = res_q;
        nops = '{C1[4'(d_q - 4'd1)], zi_q, pi_q, fx_t'(quo_q), 1'b1};
        start_pair = 1'b1;
        ret_d = S_UPD_WR;
      end
      S_UPD_WR: begin
        zr_d = tmp_q;
        zi_d = res_q;
        if (tmp_q > DIVERGE || tmp_q < -DIVERGE || res_q > DIVERGE || res_q < -DIVERGE) begin
          code_d = 4'd0;
          count_d = step_q;
          done_d = 1'b1;
          state_d = S_IDLE;
        end else begin
          k_d = '0;
          state_d = S_DIST;
        end
      end
      S_DIST: begin
        if (4'(k_q) > d_q) begin
          if (step_q == cap_q) begin
            code_d = 4'd0;
            count_d = cap_q;
            done_d = 1'b1;
            state_d = S_IDLE;
          end else begin
            step_d = step_q + 8'd1;
            state_d = S_ITER;
          end
        end else begin
          nops = '{dr, dr, di, di, 1'b0};
          start_pair = 1'b1;
          ret_d = S_DCHK;
        end
      end
      S_DCHK: begin
        if (res_q < THRESH) begin
          code_d = 4'(k_q);
          count_d = step_q;
          done_d = 1'b1;
          state_d = S_IDLE;
        end else begin
          k_d = k_q + KW'(1);
          state_d = S_DIST;
        end
      end
      default: state_d = S_IDLE;
    endcase

    if (start_pair) begin
      ops_d = nops;
      half_d = 1'b0;
      pp_d = 2'd0;
      acc_d = '0;
      state_d = S_MUL;
    end
    if (start_div) begin
      rem_d = '0;
      quo_d = dvd;
      dcnt_d = '0;
      state_d = S_DIV;
    end
    if (state_q == S_IDLE && start) step_d = 8'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      done_q <= 1'b0;
      exponent_q <= 4'd3;
      image_side_q <= 13'd1024;
      iteration_cap_q <= 8'd255;
    end else begin
      state_q <= state_d;
      done_q <= done_d;
      if (cfg_we) begin
        case (paddr[3:2])
          REG_EXPONENT: exponent_q <= pwdata[3:0];
          REG_SIDE:     image_side_q <= pwdata[12:0];
          REG_CAP:      iteration_cap_q <= pwdata[7:0];
          default:      ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    ret_q <= ret_d; d_q <= d_d; cap_q <= cap_d; step_q <= step_d; row_q <= row_d;
    k_q <= k_d; zr_q <= zr_d; zi_q <= zi_d; pr_q <= pr_d; pi_q <= pi_d; tmp_q <= tmp_d;
    f0_q <= f0_d; res_q <= res_d; ops_q <= ops_d; half_q <= half_d; pp_q <= pp_d;
    acc_q <= acc_d; rem_q <= rem_d; quo_q <= quo_d; dvs_q <= dvs_d; dcnt_q <= dcnt_d;
    code_q <= code_d; count_q <= count_d;
    if (root_we) begin
      root_re_q[root_wa] <= root_wre;
      root_im_q[root_wa] <= root_wim;
    end
  end

endmodule

// File: sim/testbench.sv
// testbench for newton_fractal_pixel: directed and random pixels checked against
// a fixed-point newton predictor held in a small scoreboard class
// depends on nfp_pkg and newton_fractal_pixel
`timescale 1ns / 1ps

module testbench;
  import nfp_pkg::*;

  typedef struct {
    logic [3:0] code;
    logic [7:0] count;
  } pixel_res_t;

  class pixel_scoreboard;
    logic [3:0]  degree_reg;
    logic [12:0] side_reg;
    logic [7:0]  cap_reg;
    pixel_res_t  pending[$];
    int          mismatches;

    function new();
      degree_reg = 4'd3;
      side_reg   = 13'd1024;
      cap_reg    = 8'd255;
      mismatches = 0;
    endfunction

    function longint sat_add(longint a, longint b);
      logic signed [64:0] s;
      s = {a[63], a} + {b[63], b};
      if (s > 65'sd4611686018427387903) return LIMIT;
      if (s < -65'sd4611686018427387903) return -LIMIT;
      return longint'(s);
    endfunction

    function longint fmul(longint a, longint b);
      logic [63:0]  x;
      logic [63:0]  y;
      logic [127:0] p;
      logic [127:0] m;
      x = (a < 0) ? -a : a;
      y = (b < 0) ? -b : b;
      p = x * y;
      m = p >> FRAC;
      if (m > 128'(LIMIT)) m = 128'(LIMIT);
      return ((a < 0) != (b < 0)) ? -longint'(m[63:0]) : longint'(m[63:0]);
    endfunction

    function longint dec_to_fx(longint v);
      logic [63:0] m;
      logic [63:0] r;
      m = (v < 0) ? -v : v;
      r = ((m << FRAC) + 64'd500000000) / 64'd1000000000;
      return (v < 0) ? -longint'(r) : longint'(r);
    endfunction

    function longint map_start(logic [11:0] idx, logic [63:0] side);
      logic [63:0] q;
      q = ((64'd4 * idx) << FRAC) / side;
      return longint'(q) - (longint'(2) << FRAC);
    endfunction

    function longint dist_sq(longint zr, longint zi, longint wr, longint wi);
      longint dr;
      longint di;
      dr = sat_add(zr, -wr);
      di = sat_add(zi, -wi);
      return sat_add(fmul(dr, dr), fmul(di, di));
    endfunction

    function pixel_res_t solve_pixel(logic [11:0] col, logic [11:0] row);
      longint     base_re[9];
      longint     base_im[9];
      longint     wr[10];
      longint     wi[10];
      longint     zr, zi, c1, pr, pim, tr, ti, sum, t, r;
      longint     d, side, cap;
      pixel_res_t res;
      bit         decided;
      base_re = '{1000000000, -1000000000, -500000000, 0, 309016994, 500000000,
                  623489802, 707106781, 766044443};
      base_im = '{0, 0, 866025404, 1000000000, 951056516, 866025404,
                  781831482, 707106781, 642787610};
      d = degree_reg;
      if (d == 0) d = 1;
      if (d > 9) d = 9;
      side = side_reg;
      if (side == 0) side = 1;
      if (side > 4096) side = 4096;
      cap = cap_reg;
      if (cap == 0) cap = 1;
      wr[0] = 0;
      wi[0] = 0;
      wr[1] = dec_to_fx(base_re[d-1]);
      wi[1] = dec_to_fx(base_im[d-1]);
      for (int k = 2; k <= d; k++) begin
        wr[k] = sat_add(fmul(wr[k-1], wr[1]), -fmul(wi[k-1], wi[1]));
        wi[k] = sat_add(fmul(wr[k-1], wi[1]), fmul(wi[k-1], wr[1]));
      end
      c1 = longint'(((64'(d - 1) << FRAC) + 64'(d / 2)) / 64'(d));
      zr = map_start(col, side);
      zi = map_start(row, side);
      res.code = 0;
      res.count = cap[7:0];
      decided = 0;
      for (int s = 1; s <= cap && !decided; s++) begin
        pr = ONE;
        pim = 0;
        for (int k = 1; k < d; k++) begin
          tr = sat_add(fmul(pr, zr), -fmul(pim, zi));
          ti = sat_add(fmul(pr, zi), fmul(pim, zr));
          pr = tr;
          pim = ti;
        end
        sum = sat_add(fmul(pr, pr), fmul(pim, pim));
        t = (sum > LIMIT / d) ? LIMIT : sum * d;
        if (t == 0) begin
          res.code = 0;
          res.count = s[7:0];
          decided = 1;
        end else begin
          r = longint'((64'd1 << 56) / 64'(t));
          zr = sat_add(fmul(c1, zr), fmul(pr, r));
          zi = sat_add(fmul(c1, zi), -fmul(pim, r));
          if (zr > DIVERGE || zr < -DIVERGE || zi > DIVERGE || zi < -DIVERGE) begin
            res.code = 0;
            res.count = s[7:0];
            decided = 1;
          end else begin
            for (int k = 0; k <= d && !decided; k++) begin
              if (dist_sq(zr, zi, wr[k], wi[k]) < THRESH) begin
                res.code = k[3:0];
                res.count = s[7:0];
                decided = 1;
              end
            end
          end
        end
      end
      return res;
    endfunction

    function void note_pixel(logic [11:0] col, logic [11:0] row);
      pending.push_back(solve_pixel(col, row));
    endfunction

    function void check_result(logic [3:0] code, logic [7:0] count);
      pixel_res_t exp_res;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result code %0d count %0d", code, count);
        return;
      end
      exp_res = pending.pop_front();
      if (code !== exp_res.code || count !== exp_res.count) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected code %0d count %0d, got code %0d count %0d",
                   exp_res.code, exp_res.count, code, count);
      end
    endfunction
  endclass

  logic          clk_i;
  logic          rst_ni;
  logic          psel, penable, pwrite;
  logic [AW-1:0] paddr;
  logic [31:0]   pwdata;
  logic [31:0]   prdata;
  logic          pready;
  logic          start;
  logic          busy;
  logic [11:0]   column_index_i, row_index_i;
  logic          done_o;
  logic [3:0]    root_code_o;
  logic [7:0]    iteration_count_o;

  pixel_scoreboard sb;

  newton_fractal_pixel DUT (.*);

  always begin
    clk_i = 1'b1;
    #1;
    clk_i = 1'b0;
    #1;
  end

  always @(posedge clk_i) begin
    if (rst_ni && done_o) sb.check_result(root_code_o, iteration_count_o);
  end

  task automatic write_reg(logic [1:0] idx, logic [31:0] value);
    @(negedge clk_i);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = {idx, 2'b00};
    pwdata = value;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    if (idx == REG_EXPONENT) sb.degree_reg = value[3:0];
    else if (idx == REG_SIDE) sb.side_reg = value[12:0];
    else sb.cap_reg = value[7:0];
    @(negedge clk_i);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  task automatic idle_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 20) repeat ($urandom_range(1, 3)) @(negedge clk_i);
    else if (roll < 24) repeat ($urandom_range(20, 200)) @(negedge clk_i);
  endtask

  task automatic send_pixel(logic [11:0] col, logic [11:0] row);
    start = 1'b1;
    column_index_i = col;
    row_index_i = row;
    do @(posedge clk_i); while (busy);
    sb.note_pixel(col, row);
    @(negedge clk_i);
    start = 1'b0;
    column_index_i = 12'($urandom);
    row_index_i = 12'($urandom);
  endtask

  task automatic drain();
    while (sb.pending.size() != 0) @(negedge clk_i);
    repeat (10) @(negedge clk_i);
  endtask

  initial begin
    #100_000_000;
    $display("newton_fractal_pixel test failed");
    $finish;
  end

  initial begin
    logic [3:0]  exps[10];
    logic [12:0] sides[6];
    logic [12:0] side;
    logic [7:0]  cap;
    int          n_items, eff_side;
    logic [11:0] col, row;
    sb = new();
    exps = '{4'd0, 4'd1, 4'd9, 4'd15, 4'd2, 4'd4, 4'd5, 4'd6, 4'd7, 4'd8};
    sides = '{13'd0, 13'd1, 13'd4096, 13'd8191, 13'd3, 13'd1024};
    rst_ni = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    start = 1'b0;
    column_index_i = '0;
    row_index_i = '0;
    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // reset settings: corners, origin start, index at side, exact root start
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd4095, 12'd4095);
    send_pixel(12'd512, 12'd512);
    send_pixel(12'd768, 12'd512);
    send_pixel(12'd1024, 12'd1023);
    send_pixel(12'd0, 12'd4095);
    send_pixel(12'd4095, 12'd0);
    send_pixel(12'haaa, 12'h555);
    send_pixel(12'h555, 12'haaa);
    send_pixel(12'd256, 12'd700);
    drain();

    for (int ph = 0; ph < 40; ph++) begin
      side = (ph < 12) ? sides[ph % 6] : 13'($urandom_range(1, 8191));
      if (ph == 3 || ph == 17 || ph == 29) begin
        cap = 8'd255;
        n_items = 4;
      end else begin
        n_items = 42;
        if (ph % 7 == 1) cap = 8'd0;
        else if (ph % 7 == 2) cap = 8'd1;
        else cap = 8'($urandom_range(2, 12));
      end
      write_reg(REG_EXPONENT, (ph < 10) ? 32'(exps[ph]) : 32'($urandom_range(0, 15)));
      write_reg(REG_SIDE, 32'(side));
      write_reg(REG_CAP, 32'(cap));
      eff_side = (side == 0) ? 1 : ((side > 4096) ? 4096 : side);
      for (int i = 0; i < n_items; i++) begin
        idle_gap();
        if ($urandom_range(0, 99) < 85) begin
          col = 12'($urandom % eff_side);
          row = 12'($urandom % eff_side);
        end else begin
          col = 12'($urandom);
          row = 12'($urandom);
        end
        send_pixel(col, row);
      end
      drain();
    end

    if (sb.mismatches == 0) $display("newton_fractal_pixel test passed");
    else $display("newton_fractal_pixel test failed");
    $finish;
  end

endmodule

// File: filelist.f
sv/nfp_pkg.sv
sv/newton_fractal_pixel.sv
sim/testbench.sv
